/* design/nstt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nstt_pkg
// Shared types, codes and tone tables for the note string to tone unit.
// ----------------------------------------------------------------------------
package nstt_pkg;

   localparam int CSR_INDEX_W = 4;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_BPM = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TPB = 4'd1;

   localparam logic [15:0] BPM_RESET  = 16'd120;
   localparam logic [15:0] TPB_RESET  = 16'd4;
   localparam logic [15:0] MS_PER_MIN = 16'd60000;
   localparam logic [7:0]  TICK_RESET = 8'd4;

   // accidental codes
   localparam logic [1:0] ACC_NONE  = 2'd0;
   localparam logic [1:0] ACC_SHARP = 2'd1;
   localparam logic [1:0] ACC_FLAT  = 2'd2;

   localparam logic [2:0] TONE_REST = 3'd7;

   typedef struct packed {
      logic [7:0] note_char;
      logic       last_char;
   } req_payload_type;

   typedef struct packed {
      logic [16:0] period_us;
      logic        is_rest;
      logic [15:0] duration_ms;
   } rsp_payload_type;

   // controller -> datapath commands
   typedef struct packed {
      logic take_char;   // accept one character into the parser
      logic finish_note; // last character: snapshot tone, clear parser
      logic div_load1;   // divider: 60000 / bpm
      logic div_load2;   // divider: quotient / ticks
      logic div_step;    // one restoring step
      logic mul;         // ms per tick times ticks
      logic load_out;    // move result into output register
   } ctrl_cmd_type;

   function automatic logic [11:0] natural_us(input logic [2:0] idx);
      logic [11:0] v;
      case (idx)
         3'd0:    v = 12'd2273;
         3'd1:    v = 12'd2025;
         3'd2:    v = 12'd3822;
         3'd3:    v = 12'd3405;
         3'd4:    v = 12'd3034;
         3'd5:    v = 12'd2863;
         3'd6:    v = 12'd2551;
         default: v = 12'd0;
      endcase
      return v;
   endfunction

   function automatic logic [11:0] sharp_us(input logic [2:0] idx);
      logic [11:0] v;
      case (idx)
         3'd0:    v = 12'd2145;
         3'd2:    v = 12'd3608;
         3'd3:    v = 12'd3214;
         3'd5:    v = 12'd2703;
         3'd6:    v = 12'd2408;
         default: v = 12'd0;
      endcase
      return v;
   endfunction

endpackage

/* design/nstt_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nstt_ctrl
// Sequencer: character intake, two divides, multiply, result handoff.
// ----------------------------------------------------------------------------
module nstt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_last,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output nstt_pkg::ctrl_cmd_type cmd
);
   import nstt_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIV1  = 3'd1;
   localparam logic [2:0] ST_LOAD2 = 3'd2;
   localparam logic [2:0] ST_DIV2  = 3'd3;
   localparam logic [2:0] ST_MUL   = 3'd4;
   localparam logic [2:0] ST_HOLD  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.take_char = 1'b1;
               if (req_last) begin
                  cmd.finish_note = 1'b1;
                  cmd.div_load1   = 1'b1;
                  step_in         = '0;
                  state_in        = ST_DIV1;
               end
            end
         end
         ST_DIV1: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 4'd1;
            if (step_ff == 4'hf) state_in = ST_LOAD2;
         end
         ST_LOAD2: begin
            cmd.div_load2 = 1'b1;
            step_in       = '0;
            state_in      = ST_DIV2;
         end
         ST_DIV2: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 4'd1;
            if (step_ff == 4'hf) state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* design/nstt_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nstt_dpath
// Parser registers, tone lookup, shared restoring divider, tick multiply,
// tempo registers and the result register.
// ----------------------------------------------------------------------------
module nstt_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  nstt_pkg::ctrl_cmd_type           cmd,
   input  nstt_pkg::req_payload_type        req_data,
   input  logic                             csr_write,
   input  logic [nstt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]                      csr_wdata,
   output nstt_pkg::rsp_payload_type        rsp_data
);
   import nstt_pkg::*;

   localparam logic [2:0] PH_LETTER = 3'd0;
   localparam logic [2:0] PH_POS1   = 3'd1;
   localparam logic [2:0] PH_OCTAVE = 3'd2;
   localparam logic [2:0] PH_COLON  = 3'd3;
   localparam logic [2:0] PH_DIGIT1 = 3'd4;
   localparam logic [2:0] PH_DIGIT2 = 3'd5;
   localparam logic [2:0] PH_IGNORE = 3'd6;

   logic [15:0] bpm_ff, tpb_ff;
   logic [2:0]  phase_ff, phase_in;
   logic [2:0]  tone_ff, tone_in;
   logic [1:0]  acc_ff, acc_in;
   logic [4:0]  oct_ff, oct_in;
   logic [7:0]  tick_ff, tick_in;

   logic [16:0] period_ff;
   logic        rest_ff;
   logic [7:0]  note_tick_ff;
   logic [15:0] dur_ff;
   logic [15:0] quo_ff, rem_ff, divisor_ff;
   rsp_payload_type rsp_ff;

   logic [7:0]  c;
   logic [4:0]  low5;
   logic [16:0] trial;

   logic [2:0]        fidx;
   logic signed [5:0] sh;
   logic [5:0]        neg_sh;
   logic [11:0]       entry;
   logic [16:0]       period_calc;

   assign c    = req_data.note_char;
   assign low5 = c[4:0];

   // parser next state
   always_comb begin
      phase_in = phase_ff;
      tone_in  = tone_ff;
      acc_in   = acc_ff;
      oct_in   = oct_ff;
      tick_in  = tick_ff;
      case (phase_ff)
         PH_LETTER: begin
            tone_in  = (low5 >= 5'd1 && low5 <= 5'd7) ? 3'(low5 - 5'd1) : TONE_REST;
            phase_in = PH_POS1;
         end
         PH_POS1: begin
            if (c == "#" || c == "b") begin
               acc_in   = (c == "b") ? ACC_FLAT : ACC_SHARP;
               phase_in = PH_OCTAVE;
            end else if (c == ":") begin
               phase_in = PH_DIGIT1;
            end else begin
               oct_in   = {1'b0, c[3:0]} + 5'd28;
               phase_in = PH_COLON;
            end
         end
         PH_OCTAVE: begin
            if (c == ":") begin
               phase_in = PH_DIGIT1;
            end else begin
               oct_in   = {1'b0, c[3:0]} + 5'd28;
               phase_in = PH_COLON;
            end
         end
         PH_COLON: phase_in = (c == ":") ? PH_DIGIT1 : PH_IGNORE;
         PH_DIGIT1: begin
            tick_in  = {4'd0, c[3:0]};
            phase_in = PH_DIGIT2;
         end
         PH_DIGIT2: begin
            tick_in  = (tick_ff << 3) + (tick_ff << 1) + {4'd0, c[3:0]};
            phase_in = PH_IGNORE;
         end
         default: phase_in = PH_IGNORE;
      endcase
   end

   // tone period from the parser state including this character
   always_comb begin
      fidx = tone_in;
      sh   = signed'({oct_in[4], oct_in});
      if (acc_in == ACC_FLAT) begin
         fidx = (tone_in == 3'd0) ? 3'd6 : tone_in - 3'd1;
         if (fidx == 3'd1) sh = sh - 6'sd1;   // Cb: natural B, octave down
         entry = (fidx == 3'd1 || fidx == 3'd4) ? natural_us(fidx) : sharp_us(fidx);
      end else if (acc_in == ACC_SHARP) begin
         entry = sharp_us(fidx);
      end else begin
         entry = natural_us(fidx);
      end
      neg_sh = 6'(-sh);
      if (sh >= 0) period_calc = {5'd0, entry} >> sh[3:0];
      else         period_calc = {5'd0, entry} << neg_sh[2:0];
   end

   assign trial = {rem_ff, quo_ff[15]} - {1'b0, divisor_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         bpm_ff   <= BPM_RESET;
         tpb_ff   <= TPB_RESET;
         phase_ff <= PH_LETTER;
         tone_ff  <= '0;
         acc_ff   <= ACC_NONE;
         oct_ff   <= '0;
         tick_ff  <= TICK_RESET;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_BPM: bpm_ff <= csr_wdata;
               CSR_TPB: tpb_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.take_char) begin
            if (cmd.finish_note) begin
               phase_ff <= PH_LETTER;
               tone_ff  <= '0;
               acc_ff   <= ACC_NONE;
               oct_ff   <= '0;
               tick_ff  <= TICK_RESET;
            end else begin
               phase_ff <= phase_in;
               tone_ff  <= tone_in;
               acc_ff   <= acc_in;
               oct_ff   <= oct_in;
               tick_ff  <= tick_in;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.finish_note) begin
         rest_ff      <= (tone_in == TONE_REST);
         period_ff    <= (tone_in == TONE_REST) ? '0 : period_calc;
         note_tick_ff <= tick_in;
      end
      if (cmd.div_load1) begin
         quo_ff     <= MS_PER_MIN;
         rem_ff     <= '0;
         divisor_ff <= (bpm_ff == '0) ? 16'd1 : bpm_ff;
      end else if (cmd.div_load2) begin
         quo_ff     <= quo_ff;
         rem_ff     <= '0;
         divisor_ff <= (tpb_ff == '0) ? 16'd1 : tpb_ff;
      end else if (cmd.div_step) begin
         if (!trial[16]) begin
            rem_ff <= trial[15:0];
            quo_ff <= {quo_ff[14:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[14:0], quo_ff[15]};
            quo_ff <= {quo_ff[14:0], 1'b0};
         end
      end
      if (cmd.mul) dur_ff <= quo_ff[7:0] * note_tick_ff;
      if (cmd.load_out) begin
         rsp_ff.period_us   <= period_ff;
         rsp_ff.is_rest     <= rest_ff;
         rsp_ff.duration_ms <= dur_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

/* design/note_string_to_tone_unit.sv */
// Sequence: a character that is not last goes straight into the parser; the
//   last one is followed by two 16-step restoring divides with one load
//   between them, one multiply and one handoff before the result is valid,
//   plus any wait for the output register.
// Throughput: one character per cycle until a last character; then the
//   intake stays closed while the shared divider runs, and longer while an
//   earlier result still waits in the output register.
// Reset: synchronous, active high; tempo 120 bpm, 4 ticks, parser at letter.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// note_string_to_tone_unit
// Parses note strings one character per transfer and returns tone period,
// rest flag and duration for each string.
// ----------------------------------------------------------------------------
module note_string_to_tone_unit (
   input  logic                             clock,
   input  logic                             reset,
   // character transfers
   input  logic                             req_valid,
   output logic                             req_ready,
   input  nstt_pkg::req_payload_type        req_data,
   // result transfers
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output nstt_pkg::rsp_payload_type        rsp_data,
   // tempo register writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [nstt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]                      csr_wdata
);
   import nstt_pkg::*;

   ctrl_cmd_type cmd;

   // register writes are always taken; software must write only while idle, the block does not enforce it
   assign csr_ready = 1'b1;

   // sequencer: decides when a character is taken and walks the
   // divide / multiply steps after the last character of a string
   nstt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_last  (req_data.last_char),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // datapath: parser, tone table, divider, multiplier, output register;
   // the output register lets the next string be parsed while a result waits
   nstt_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

endmodule

/* tb/note_tone_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// note_tone_checker
// Watches the character, result and tempo register channels, predicts each
// note's tone period, rest flag and duration, and compares them in order.
// ----------------------------------------------------------------------------
module note_tone_checker
   import nstt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  req_payload_type        req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rsp_payload_type        rsp_data,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]            csr_wdata,
   output int                     mismatch_count,
   output int                     results_owed
);

   typedef enum logic [2:0] {
      ST_LETTER,
      ST_MODIFIER,
      ST_OCTAVE,
      ST_COLON,
      ST_DIGIT1,
      ST_DIGIT2,
      ST_SKIP
   } parse_step_e;

   localparam logic [7:0] CHAR_SHARP = 8'h23;
   localparam logic [7:0] CHAR_FLAT  = 8'h62;
   localparam logic [7:0] CHAR_COLON = 8'h3a;

   // octave 4 periods, index 0 is A; leftmost element is index 6
   localparam logic [6:0][11:0] NATURAL_TABLE = {12'd2551, 12'd2863, 12'd3034,
      12'd3405, 12'd3822, 12'd2025, 12'd2273};
   localparam logic [6:0][11:0] SHARP_TABLE = {12'd2408, 12'd2703, 12'd0,
      12'd3214, 12'd3608, 12'd0, 12'd2145};

   parse_step_e     step;
   logic [2:0]      tone;
   logic [1:0]      accidental;
   logic [4:0]      octave;
   logic [7:0]      ticks;
   logic [15:0]     bpm;
   logic [15:0]     tpb;
   rsp_payload_type tone_queue[$];

   task automatic clear_parse();
      step       = ST_LETTER;
      tone       = 3'd0;
      accidental = ACC_NONE;
      octave     = 5'd0;
      ticks      = TICK_RESET;
   endtask

   // advance the parser by one character; on the last one queue the result
   task automatic absorb_char(input req_payload_type item);
      logic [7:0]      c;
      logic [7:0]      slot;
      logic [15:0]     b;
      logic [15:0]     t;
      logic [15:0]     per_tick;
      logic [2:0]      idx;
      logic [16:0]     entry;
      int              sh;
      rsp_payload_type tone_out;
      c = item.note_char;
      case (step)
         ST_LETTER: begin
            slot = {3'b000, c[4:0]} - 8'd1;
            tone = (slot < 8'd7) ? slot[2:0] : TONE_REST;
            step = ST_MODIFIER;
         end
         ST_MODIFIER: begin
            if (c == CHAR_SHARP || c == CHAR_FLAT) begin
               accidental = (c == CHAR_FLAT) ? ACC_FLAT : ACC_SHARP;
               step       = ST_OCTAVE;
            end else if (c == CHAR_COLON) begin
               step = ST_DIGIT1;
            end else begin
               octave = {1'b0, c[3:0]} + 5'd28;
               step   = ST_COLON;
            end
         end
         ST_OCTAVE: begin
            if (c == CHAR_COLON) begin
               step = ST_DIGIT1;
            end else begin
               octave = {1'b0, c[3:0]} + 5'd28;
               step   = ST_COLON;
            end
         end
         ST_COLON: step = (c == CHAR_COLON) ? ST_DIGIT1 : ST_SKIP;
         ST_DIGIT1: begin
            ticks = {4'd0, c[3:0]};
            step  = ST_DIGIT2;
         end
         ST_DIGIT2: begin
            ticks = ticks * 8'd10 + {4'd0, c[3:0]};
            step  = ST_SKIP;
         end
         default: step = ST_SKIP;
      endcase
      if (!item.last_char) return;

      b        = (bpm == 16'd0) ? 16'd1 : bpm;
      t        = (tpb == 16'd0) ? 16'd1 : tpb;
      per_tick = (MS_PER_MIN / b) / t;
      tone_out.duration_ms = {8'd0, per_tick[7:0]} * {8'd0, ticks};
      tone_out.is_rest     = (tone == TONE_REST);

      // flat is the sharp of the letter below; Cb and Fb fall on naturals
      idx = tone;
      sh  = octave[4] ? int'(octave) - 32 : int'(octave);
      case (accidental)
         ACC_FLAT: begin
            idx = (idx == 3'd0) ? 3'd6 : idx - 3'd1;
            if (idx == 3'd1) sh = sh - 1;
            entry = (idx == 3'd1 || idx == 3'd4) ? NATURAL_TABLE[idx] : SHARP_TABLE[idx];
         end
         ACC_SHARP: entry = SHARP_TABLE[idx];
         default:   entry = NATURAL_TABLE[idx];
      endcase
      if (tone_out.is_rest) tone_out.period_us = 17'd0;
      else if (sh >= 0)     tone_out.period_us = entry >> sh;
      else                  tone_out.period_us = entry << (-sh);

      tone_queue.push_back(tone_out);
      clear_parse();
   endtask

   always @(posedge clock) begin : watch
      rsp_payload_type want;
      if (reset) begin
         clear_parse();
         bpm = BPM_RESET;
         tpb = TPB_RESET;
         tone_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BPM: bpm = csr_wdata;
               CSR_TPB: tpb = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) absorb_char(req_data);
         if (rsp_valid && rsp_ready) begin
            if (tone_queue.size() == 0) begin
               $error("result transfer with nothing expected: %p", rsp_data);
               mismatch_count++;
            end else begin
               want = tone_queue.pop_front();
               if (rsp_data.period_us !== want.period_us) begin
                  $error("period_us: expected %0d, actual %0d",
                         want.period_us, rsp_data.period_us);
                  mismatch_count++;
               end
               if (rsp_data.is_rest !== want.is_rest) begin
                  $error("is_rest: expected %0d, actual %0d", want.is_rest, rsp_data.is_rest);
                  mismatch_count++;
               end
               if (rsp_data.duration_ms !== want.duration_ms) begin
                  $error("duration_ms: expected %0d, actual %0d",
                         want.duration_ms, rsp_data.duration_ms);
                  mismatch_count++;
               end
            end
         end
      end
      results_owed <= tone_queue.size();
   end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds note strings one character per transfer into the note string to tone
// unit under several tempo settings, with random gaps and stalls, and leaves
// prediction and comparison to the tone checker beside it.
// ----------------------------------------------------------------------------
module testbench;
   import nstt_pkg::*;

   typedef logic [7:0] char_queue_type[$];

   // wait after the last result, longer than a last character's run through the divider
   localparam int DRAIN_CYCLES     = 40;
   localparam int HOLD_OFF_CYCLES  = 300;
   localparam int CHARS_PER_PHASE  = 340;
   localparam int PHASES           = 6;
   // index with no register behind it; writes there must change nothing
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 4'hF;

   localparam logic [7:0] CHAR_SHARP   = 8'h23;
   localparam logic [7:0] CHAR_FLAT    = 8'h62;
   localparam logic [7:0] CHAR_COLON   = 8'h3a;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_payload_type        req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_payload_type        rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_BPM;
   logic [15:0]            csr_wdata = 16'd0;

   int mismatch_count;
   int results_owed;
   int chars_sent = 0;

   // idling switches; both go off for the final quiet phase
   bit sender_gaps     = 1'b1;
   bit receiver_stalls = 1'b1;
   // set by the stimulus, cleared by the receiver once the hold-off is done
   bit hold_off_req    = 1'b0;

   always #5 clock = ~clock;

   note_string_to_tone_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   note_tone_checker tone_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   // One character transfer. An optional gap drops valid first; otherwise
   // valid stays high straight into the next transfer.
   task automatic send_char(input logic [7:0] c, input logic last);
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{note_char: c, last_char: last};
      do @(posedge clock); while (!req_ready);
      chars_sent++;
   endtask

   task automatic send_note(input char_queue_type q);
      for (int i = 0; i < q.size(); i++) send_char(q[i], i == q.size() - 1);
   endtask

   // valid is left high by the write; the caller drops it after the last one
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Stop offering characters, wait for every owed result, then let the
   // divider finish anything still in flight. The first edge lets the
   // checker's count catch up with the transfer just made.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (results_owed == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic char_queue_type text_chars(input string s);
      char_queue_type q;
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
      return q;
   endfunction

   // mostly a decimal digit, sometimes any byte (reaches octave nibbles 10..15)
   function automatic logic [7:0] digit_char();
      if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
      return CHAR_ZERO + 8'($urandom_range(0, 9));
   endfunction

   // Mostly well-formed notes with random content: letter, accidental,
   // octave, colon and digits, trailing junk. Some are cut short, some
   // are plain noise bytes.
   function automatic char_queue_type random_note();
      char_queue_type q;
      logic [7:0]     letter;
      int             n;
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(0, 255)));
         return q;
      end
      letter = ($urandom_range(0, 9) < 7) ? CHAR_LOWER_A + 8'($urandom_range(0, 6))
                                          : 8'($urandom_range(0, 255));
      if ($urandom_range(0, 1) == 1) letter[5] = 1'b0;  // upper case
      q.push_back(letter);
      case ($urandom_range(0, 4))
         0:       q.push_back(CHAR_SHARP);
         1:       q.push_back(CHAR_FLAT);
         default: ;
      endcase
      if ($urandom_range(0, 4) != 0) q.push_back(digit_char());
      if ($urandom_range(0, 2) != 0) begin
         q.push_back(CHAR_COLON);
         repeat ($urandom_range(0, 2)) q.push_back(digit_char());
      end
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) q.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, q.size());
         while (q.size() > n) void'(q.pop_back());
      end
      return q;
   endfunction

   // Receiver: random ready bursts, plus one long hold-off on request so the
   // output register fills and the unit closes its intake.
   initial begin
      wait (!reset);
      forever begin
         if (hold_off_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      int  phase_start;
      bit  held;
      bit  paused;
      held   = 1'b0;
      paused = 1'b0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed notes at reset tempo: one-letter strings, zero and all-ones
      // characters as letters, B sharp and E sharp (silent but not a rest),
      // C flat down an octave, F flat, A flat wrapping to G sharp, colon with
      // no digit, two-digit duration overflowing 8 bits, rest letter with a
      // duration and trailing junk, colon right after the letter.
      send_note(text_chars("a"));
      send_note('{8'h00});
      send_note('{8'hff});
      send_note(text_chars("b#4"));
      send_note(text_chars("E#"));
      send_note(text_chars("cb0"));
      send_note(text_chars("Fb:"));
      send_note(text_chars("ab9"));
      send_note(text_chars("g4:99"));
      send_note(text_chars("h7:1x"));
      send_note(text_chars("c:8"));

      for (int p = 0; p < PHASES; p++) begin
         settle();
         case (p)
            0: begin
               // 60000 ms per tick, truncated to 8 bits
               csr_write(CSR_BPM, 16'd1);
               csr_write(CSR_TPB, 16'd1);
            end
            1: begin
               csr_write(CSR_BPM, 16'hffff);
               csr_write(CSR_TPB, 16'hffff);
            end
            2: begin
               // zeros count as one; spare index must leave both alone
               csr_write(CSR_BPM, 16'd0);
               csr_write(CSR_TPB, 16'd0);
               csr_write(CSR_SPARE, 16'hffff);
            end
            3: begin
               // 255 ms per tick, the largest that survives truncation
               csr_write(CSR_BPM, 16'd235);
               csr_write(CSR_TPB, 16'd1);
            end
            4: begin
               csr_write(CSR_BPM, 16'($urandom_range(30, 300)));
               csr_write(CSR_TPB, 16'($urandom_range(1, 16)));
            end
            default: begin
               csr_write(CSR_BPM, 16'($urandom_range(60, 180)));
               csr_write(CSR_TPB, 16'($urandom_range(1, 4)));
            end
         endcase
         csr_valid <= 1'b0;

         // last phase runs back to back on both sides
         if (p == PHASES - 1) begin
            sender_gaps     = 1'b0;
            receiver_stalls = 1'b0;
         end

         phase_start = chars_sent;
         while (chars_sent - phase_start < CHARS_PER_PHASE) begin
            // keep sending through the receiver's hold-off
            if (p == 1 && !held && chars_sent - phase_start > 100) begin
               hold_off_req = 1'b1;
               held         = 1'b1;
            end
            // sender pause until everything owed has come back
            if (p == 2 && !paused && chars_sent - phase_start > 150) begin
               settle();
               paused = 1'b1;
            end
            send_note(random_note());
         end
      end

      settle();
      if (mismatch_count == 0 && results_owed == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // timeout: far beyond the slowest correct run
   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

/* sim.f */
design/nstt_pkg.sv
design/nstt_ctrl.sv
design/nstt_dpath.sv
design/note_string_to_tone_unit.sv
tb/note_tone_checker.sv
tb/testbench.sv
